### src/raw_rgba_header_validator_core_macros.svh
// ----------------------------------------------------------------------------
// raw_rgba_header_validator_core_macros.svh
// assertion macros used by the header validator core
// ----------------------------------------------------------------------------
`ifndef RAW_RGBA_HEADER_VALIDATOR_CORE_MACROS_SVH
`define RAW_RGBA_HEADER_VALIDATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RHV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RHV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rhv_pkg.sv
// ----------------------------------------------------------------------------
// rhv_pkg
// types, constants and helpers of the raw rgba header validator
// ----------------------------------------------------------------------------
`default_nettype none

package rhv_pkg;

    localparam int unsigned MAX_DIMENSION = 16384;
    localparam int unsigned DIM_W         = 15;
    localparam int unsigned CNT_W         = 31;
    localparam int unsigned PROD_W        = 2 * DIM_W;
    localparam int unsigned MAGIC_LEN     = 10;
    localparam int unsigned POS_W         = 4;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [3:0] {
        PH_MAGIC    = 4'd0,
        PH_W_LEAD   = 4'd1,
        PH_W_SIGN   = 4'd2,
        PH_W_DIGITS = 4'd3,
        PH_H_LEAD   = 4'd4,
        PH_H_SIGN   = 4'd5,
        PH_H_DIGITS = 4'd6,
        PH_PAYLOAD  = 4'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic             image_ok;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } out_item_t;

    typedef struct packed {
        phase_t phase;
        logic   failed;
    } prs_stat_t;

    // expected file signature, one byte per position
    function automatic logic [7:0] magic_at(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h4C;
            4'd1:    c = 8'h55;
            4'd2:    c = 8'h4D;
            4'd3:    c = 8'h45;
            4'd4:    c = 8'h4E;
            4'd5:    c = 8'h52;
            4'd6:    c = 8'h47;
            4'd7:    c = 8'h42;
            4'd8:    c = 8'h41;
            4'd9:    c = CH_NEWLINE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### src/rhv_in_if.sv
// ----------------------------------------------------------------------------
// rhv_in_if
// byte channel: one file byte and its end-of-file flag per request
// ----------------------------------------------------------------------------
`default_nettype none

interface rhv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### src/rhv_out_if.sv
// ----------------------------------------------------------------------------
// rhv_out_if
// result channel: verdict and dimensions of one file per request
// ----------------------------------------------------------------------------
`default_nettype none

interface rhv_out_if;
    logic        valid;
    logic        ready;
    logic        image_ok;
    logic [14:0] image_width;
    logic [14:0] image_height;

    modport source (output valid, output image_ok, output image_width,
                    output image_height, input ready);
    modport sink   (input valid, input image_ok, input image_width,
                    input image_height, output ready);
endinterface

`default_nettype wire

### src/rhv_in_stage.sv
// ----------------------------------------------------------------------------
// rhv_in_stage
// input register of the byte channel
// ----------------------------------------------------------------------------
`default_nettype none

module rhv_in_stage
    import rhv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rhv_in_if.sink    byte_chan,
    input  wire logic take,
    output logic      item_valid,
    output in_item_t  item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // refill whenever the held byte leaves or the stage is empty
    assign byte_chan.ready = !valid_reg || take;
    assign load            = byte_chan.valid && byte_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte <= byte_chan.data_byte;
            item_reg.last_byte <= byte_chan.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### src/rhv_parser.sv
// ----------------------------------------------------------------------------
// rhv_parser
// per-byte header parser, payload counter and final verdict
// ----------------------------------------------------------------------------
`default_nettype none

module rhv_parser
    import rhv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire in_item_t item,
    output out_item_t     result,
    output prs_stat_t     stat
);

    localparam int unsigned ACC_W = DIM_W + 3;
    localparam logic [DIM_W-1:0] CAP     = DIM_W'(MAX_DIMENSION + 1);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [DIM_W-1:0]   w_reg, w_next;
    logic [DIM_W-1:0]   h_reg, h_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               fail_reg, fail_next;
    logic [PROD_W-1:0]  prod_reg;

    logic [7:0]         b;
    logic               b_space;
    logic               b_digit;
    logic               b_sign;
    logic [DIM_W-1:0]   acc_w;
    logic [DIM_W-1:0]   acc_h;
    logic [CNT_W-1:0]   cnt_inc;
    logic               do_lead;
    logic               lead_h;
    logic               ok;

    // value * 10 + digit, clamped one above the largest legal dimension
    function automatic logic [DIM_W-1:0] accumulate(input logic [DIM_W-1:0] v,
                                                    input logic [7:0] c);
        logic [ACC_W-1:0] t;
        t = {v, 3'b000} + {2'b00, v, 1'b0} + ACC_W'(c - CH_ZERO);
        return (t > ACC_W'(CAP)) ? CAP : t[DIM_W-1:0];
    endfunction

    assign b       = item.data_byte;
    assign b_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign b_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign b_sign  = (b == CH_PLUS) || (b == CH_MINUS);
    assign acc_w   = accumulate(w_reg, b);
    assign acc_h   = accumulate(h_reg, b);
    assign cnt_inc = (cnt_reg == CNT_SAT) ? cnt_reg : cnt_reg + CNT_W'(1);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        fail_next  = fail_reg;
        do_lead    = 1'b0;
        lead_h     = 1'b0;

        if (step && !fail_reg)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if ((pos_reg >= POS_W'(MAGIC_LEN)) || (b != magic_at(pos_reg)))
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(MAGIC_LEN - 1))
                        begin
                            neg_next   = 1'b0;
                            phase_next = PH_W_LEAD;
                        end
                    end
                end
                PH_W_LEAD:
                begin
                    do_lead = 1'b1;
                end
                PH_H_LEAD:
                begin
                    do_lead = 1'b1;
                    lead_h  = 1'b1;
                end
                PH_W_SIGN:
                begin
                    if (!b_digit)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        w_next     = acc_w;
                        phase_next = PH_W_DIGITS;
                    end
                end
                PH_H_SIGN:
                begin
                    if (!b_digit)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        h_next     = acc_h;
                        phase_next = PH_H_DIGITS;
                    end
                end
                PH_W_DIGITS:
                begin
                    if (b_digit)
                    begin
                        w_next = acc_w;
                    end
                    else if (neg_reg)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        // the height lead starts on this same byte
                        neg_next   = 1'b0;
                        phase_next = PH_H_LEAD;
                        do_lead    = 1'b1;
                        lead_h     = 1'b1;
                    end
                end
                PH_H_DIGITS:
                begin
                    if (b_digit)
                    begin
                        h_next = acc_h;
                    end
                    else if (neg_reg || (b != CH_NEWLINE))
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    cnt_next = cnt_inc;
                end
                default:
                begin
                    fail_next = 1'b1;
                end
            endcase

            // whitespace skip, optional sign, first digit
            if (do_lead)
            begin
                priority if (b_space)
                begin
                end
                else if (b_sign)
                begin
                    neg_next   = (b == CH_MINUS);
                    phase_next = lead_h ? PH_H_SIGN : PH_W_SIGN;
                end
                else if (b_digit)
                begin
                    if (lead_h)
                    begin
                        h_next     = acc_h;
                        phase_next = PH_H_DIGITS;
                    end
                    else
                    begin
                        w_next     = acc_w;
                        phase_next = PH_W_DIGITS;
                    end
                end
                else
                begin
                    fail_next = 1'b1;
                end
            end
        end

        // end of file: back to the start for the next one
        if (step && item.last_byte)
        begin
            phase_next = PH_MAGIC;
            pos_next   = '0;
            w_next     = '0;
            h_next     = '0;
            neg_next   = 1'b0;
            cnt_next   = '0;
            fail_next  = 1'b0;
        end
    end

    // verdict for the final byte; only a byte taken inside the payload can pass
    always_comb
    begin
        ok = !fail_reg && (phase_reg == PH_PAYLOAD)
             && (w_reg != '0) && (w_reg <= DIM_MAX)
             && (h_reg != '0) && (h_reg <= DIM_MAX)
             && ((PROD_W + 2)'(cnt_inc) == {prod_reg, 2'b00});
        result.image_ok     = ok;
        result.image_width  = ok ? w_reg : '0;
        result.image_height = ok ? h_reg : '0;
        stat.phase          = phase_reg;
        stat.failed         = fail_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            fail_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            fail_reg  <= fail_next;
        end
    end

    // dimensions are settled before the newline, so this is current in the payload
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(w_reg) * PROD_W'(h_reg);
    end

endmodule

`default_nettype wire

### src/rhv_out_stage.sv
// ----------------------------------------------------------------------------
// rhv_out_stage
// result register of the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module rhv_out_stage
    import rhv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_item_t result,
    output logic           slot_free,
    rhv_out_if.source      result_chan
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign slot_free = !valid_reg || result_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_chan.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign result_chan.valid        = valid_reg;
    assign result_chan.image_ok     = data_reg.image_ok;
    assign result_chan.image_width  = data_reg.image_width;
    assign result_chan.image_height = data_reg.image_height;

endmodule

`default_nettype wire

### src/raw_rgba_header_validator_core.sv
// ----------------------------------------------------------------------------
// raw_rgba_header_validator_core
// streaming check of a raw rgba image file header and payload length
// ----------------------------------------------------------------------------
// The block takes a file one byte per request on byte_chan, with last_byte
// set on the final byte, and gives one request on result_chan per file: the
// ok flag plus width and height (both zero when the file is rejected). It
// checks the ten-byte signature, reads width and height as decimal numbers
// (leading whitespace, optional sign, at least one digit, height ending in a
// newline), requires both in 1..16384 and a payload of exactly
// width*height*4 bytes. It takes one byte every clock cycle with no gaps
// between files, unless a final byte waits on a full result register; a
// result is valid once its final byte has passed the input register, then
// the parser into the result register. The byte rate is set by the parser
// step; the width*height product is kept in a register updated every
// cycle, so the final compare is one add and compare. A full result register
// that is not being drained holds a final byte in the input register, and the
// byte channel waits behind it; ordinary bytes never wait on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "raw_rgba_header_validator_core_macros.svh"

module raw_rgba_header_validator_core
    import rhv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rhv_in_if.sink    byte_chan,
    rhv_out_if.source result_chan
);

    // held byte from the input register
    logic      item_valid;
    in_item_t  item;

    // a held byte moves into the parser this cycle
    logic      take;
    logic      slot_free;
    logic      load_result;

    out_item_t result;
    prs_stat_t stat;

    // an ordinary byte always advances; a final byte needs room for its result
    assign take        = item_valid && (!item.last_byte || slot_free);
    assign load_result = take && item.last_byte;

    rhv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // header phases, saturating counts and the final verdict
    rhv_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (item),
        .result (result),
        .stat   (stat)
    );

    rhv_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load_result),
        .result      (result),
        .slot_free   (slot_free),
        .result_chan (result_chan)
    );

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // every file ends with the parser back at the signature, clean
    `RHV_ASSERT_NEXT(a_restart_after_last, load_result,
        (stat.phase == PH_MAGIC) && !stat.failed, "parser not restarted after final byte")

    // an accepted file never reports a zero dimension
    `RHV_ASSERT_SAME(a_ok_dims_nonzero, result_chan.valid && result_chan.image_ok,
        (result_chan.image_width != '0) && (result_chan.image_height != '0),
        "ok result with zero dimension")

    // a rejected file reports zero dimensions
    `RHV_ASSERT_SAME(a_bad_dims_zero, result_chan.valid && !result_chan.image_ok,
        (result_chan.image_width == '0) && (result_chan.image_height == '0),
        "rejected result with nonzero dimension")

endmodule

`default_nettype wire

### test/raw_rgba_header_validator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_rgba_header_validator_core_tb
// self-checking bench for the raw rgba header validator
// ----------------------------------------------------------------------------
// Streams whole image files into the byte channel and predicts the verdict of
// each file with a parser of its own, run on every accepted byte request. Each
// result request is compared field by field with the oldest pending verdict.
// Directed files cover accepted header forms, each kind of rejection, files
// cut short and the largest dimensions; random files follow, mostly well
// formed with random numbers, whitespace, signs and payload, under several
// sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------

module raw_rgba_header_validator_core_tb;
    import rhv_pkg::*;

    // expected file signature, first byte in the top bits
    localparam logic [79:0] SIGNATURE   = 80'h4C_55_4D_45_4E_52_47_42_41_0A;
    localparam int unsigned COUNT_CAP   = 32'h7FFF_FFFF;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 10;
    localparam int unsigned REPORT_MAX  = 10;

    logic clk;
    logic rst_n;

    rhv_in_if  byte_chan ();
    rhv_out_if result_chan ();

    raw_rgba_header_validator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .result_chan (result_chan)
    );

    // pending verdicts, oldest first
    out_item_t   verdict_q[$];
    // bytes of the file being built
    logic [7:0]  file_q[$];

    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned err_count;
    int unsigned live_bytes;
    int unsigned files_sent;

    // parser state of the prediction
    phase_t      pr_phase;
    logic [3:0]  pr_mpos;
    int unsigned pr_width;
    int unsigned pr_height;
    logic        pr_neg;
    int unsigned pr_count;
    logic        pr_failed;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // strtol whitespace: space, tab, lf, vt, ff, cr
    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic bit is_decimal(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // one more decimal digit, clamped one above the largest legal dimension
    function automatic int unsigned grow_dim(input int unsigned v, input logic [7:0] b);
        int unsigned n;
        n = v * 10 + int'(b - CH_ZERO);
        return (n > MAX_DIMENSION + 1) ? MAX_DIMENSION + 1 : n;
    endfunction

    function automatic void clear_parser();
        pr_phase  = PH_MAGIC;
        pr_mpos   = '0;
        pr_width  = 0;
        pr_height = 0;
        pr_neg    = 1'b0;
        pr_count  = 0;
        pr_failed = 1'b0;
    endfunction

    // start of a number: skip blanks, optional sign, else first digit
    function automatic void take_lead(input logic [7:0] b, input bit for_height);
        if (is_blank(b))
        begin
        end
        else if (b == CH_PLUS || b == CH_MINUS)
        begin
            pr_neg   = (b == CH_MINUS);
            pr_phase = for_height ? PH_H_SIGN : PH_W_SIGN;
        end
        else if (is_decimal(b))
        begin
            if (for_height)
            begin
                pr_height = grow_dim(pr_height, b);
                pr_phase  = PH_H_DIGITS;
            end
            else
            begin
                pr_width = grow_dim(pr_width, b);
                pr_phase = PH_W_DIGITS;
            end
        end
        else
        begin
            pr_failed = 1'b1;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        case (pr_phase)
            PH_MAGIC:
            begin
                if (pr_mpos >= MAGIC_LEN || b != SIGNATURE[79 - 8 * pr_mpos -: 8])
                begin
                    pr_failed = 1'b1;
                end
                else
                begin
                    pr_mpos = pr_mpos + 1'b1;
                    if (pr_mpos == MAGIC_LEN)
                    begin
                        pr_neg   = 1'b0;
                        pr_phase = PH_W_LEAD;
                    end
                end
            end
            PH_W_LEAD: take_lead(b, 1'b0);
            PH_H_LEAD: take_lead(b, 1'b1);
            PH_W_SIGN, PH_H_SIGN:
            begin
                if (!is_decimal(b))
                begin
                    pr_failed = 1'b1;
                end
                else if (pr_phase == PH_W_SIGN)
                begin
                    pr_width = grow_dim(pr_width, b);
                    pr_phase = PH_W_DIGITS;
                end
                else
                begin
                    pr_height = grow_dim(pr_height, b);
                    pr_phase  = PH_H_DIGITS;
                end
            end
            PH_W_DIGITS:
            begin
                if (is_decimal(b))
                begin
                    pr_width = grow_dim(pr_width, b);
                end
                else if (pr_neg)
                begin
                    pr_failed = 1'b1;
                end
                else
                begin
                    // height starts right here, this byte is its lead
                    pr_neg   = 1'b0;
                    pr_phase = PH_H_LEAD;
                    take_lead(b, 1'b1);
                end
            end
            PH_H_DIGITS:
            begin
                if (is_decimal(b))
                begin
                    pr_height = grow_dim(pr_height, b);
                end
                else if (pr_neg || b != CH_NEWLINE)
                begin
                    pr_failed = 1'b1;
                end
                else
                begin
                    pr_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (pr_count < COUNT_CAP)
                begin
                    pr_count++;
                end
            end
            default: pr_failed = 1'b1;
        endcase
    endfunction

    // one accepted byte request; the final byte queues a verdict
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        out_item_t   v;
        bit          ok;
        longint unsigned want_len;
        if (!pr_failed)
        begin
            live_bytes++;
            parse_byte(b);
        end
        if (last)
        begin
            ok = !pr_failed && pr_phase == PH_PAYLOAD
                 && pr_width >= 1 && pr_width <= MAX_DIMENSION
                 && pr_height >= 1 && pr_height <= MAX_DIMENSION;
            if (ok)
            begin
                want_len = longint'(pr_width) * longint'(pr_height) * 4;
                ok = (want_len == longint'(pr_count));
            end
            v.image_ok     = ok;
            v.image_width  = ok ? pr_width[DIM_W-1:0] : '0;
            v.image_height = ok ? pr_height[DIM_W-1:0] : '0;
            verdict_q.push_back(v);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_chan.valid && result_chan.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                if (err_count < REPORT_MAX)
                    $display("[%0t] result with no file pending: ok=%0b w=%0d h=%0d",
                             $time, result_chan.image_ok, result_chan.image_width,
                             result_chan.image_height);
                err_count++;
            end
            else
            begin
                if (result_chan.image_ok !== verdict_q[0].image_ok
                    || result_chan.image_width !== verdict_q[0].image_width
                    || result_chan.image_height !== verdict_q[0].image_height)
                begin
                    if (err_count < REPORT_MAX)
                        $display({"[%0t] verdict mismatch: expected ok=%0b w=%0d h=%0d,",
                                  " got ok=%0b w=%0d h=%0d"}, $time,
                                 verdict_q[0].image_ok, verdict_q[0].image_width,
                                 verdict_q[0].image_height, result_chan.image_ok,
                                 result_chan.image_width, result_chan.image_height);
                    err_count++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    // receiver: ready changes on the falling edge, stalls at random
    initial
    begin
        result_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                result_chan.ready <= 1'b0;
            else
                result_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: too many cycles with neither channel moving a request
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_chan.valid && byte_chan.ready)
                || (result_chan.valid && result_chan.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // byte sender
    // ------------------------------------------------------------------------

    // valid stays high after the request so back-to-back bytes leave no gap
    task automatic push_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_chan.valid <= 1'b0;
            @(negedge clk);
        end
        byte_chan.valid     <= 1'b1;
        byte_chan.data_byte <= b;
        byte_chan.last_byte <= last;
        do
            @(posedge clk);
        while (!byte_chan.ready);
        predict_byte(b, last);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            push_byte(file_q[i], i == file_q.size() - 1);
        files_sent++;
    endtask

    // drop valid and hold off until every pending verdict has come back
    task automatic wait_drained();
        @(negedge clk);
        byte_chan.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // file building
    // ------------------------------------------------------------------------
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_q.push_back(s[i]);
    endfunction

    function automatic void add_signature(input int unsigned n);
        for (int i = 0; i < n && i < MAGIC_LEN; i++)
            file_q.push_back(SIGNATURE[79 - 8 * i -: 8]);
    endfunction

    function automatic void add_payload(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            file_q.push_back(8'($urandom));
    endfunction

    // signature, header text, then n random payload bytes
    task automatic send_text_file(input string hdr, input int unsigned n);
        file_q.delete();
        add_signature(MAGIC_LEN);
        add_text(hdr);
        add_payload(n);
        send_file();
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NEWLINE;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return CH_CR;
        endcase
    endfunction

    // mostly tiny dimensions so payloads stay short
    function automatic int unsigned pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)      return $urandom_range(1, 4);
        else if (r < 80) return $urandom_range(5, 8);
        else if (r < 85) return 0;
        else if (r < 90) return $urandom_range(MAX_DIMENSION - 4, MAX_DIMENSION + 6);
        else if (r < 94) return $urandom_range(100000, 99999999);
        else             return $urandom_range(1, 16);
    endfunction

    // blanks, optional sign, optional leading zeros, digits
    function automatic void add_number(input int unsigned v, input bit need_gap);
        int unsigned r;
        int unsigned lead_min;
        logic [7:0]  sign;
        r    = $urandom_range(99);
        sign = (r < 85) ? 8'h00 : (r < 93) ? CH_PLUS : CH_MINUS;
        lead_min = (need_gap && sign == 8'h00) ? 1 : 0;
        repeat ($urandom_range(lead_min, 2))
            file_q.push_back(pick_blank());
        if (sign != 8'h00)
            file_q.push_back(sign);
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 2))
                file_q.push_back(CH_ZERO);
        add_text($sformatf("%0d", v));
    endfunction

    task automatic send_random_file();
        int unsigned     w;
        int unsigned     h;
        int unsigned     keep;
        longint unsigned area;
        file_q.delete();
        if ($urandom_range(99) < 8)
        begin
            // pure noise
            add_payload($urandom_range(1, 24));
        end
        else
        begin
            add_signature(MAGIC_LEN);
            if ($urandom_range(99) < 5)
                file_q[$urandom_range(0, MAGIC_LEN - 1)] = 8'($urandom);
            w = pick_dim();
            h = pick_dim();
            add_number(w, 1'b0);
            add_number(h, 1'b1);
            if ($urandom_range(99) < 92)
                file_q.push_back(CH_NEWLINE);
            else
                file_q.push_back(8'($urandom));
            area = longint'(w) * longint'(h) * 4;
            if (area <= 1024 && $urandom_range(99) < 80)
                add_payload(32'(area));
            else if (area <= 1024 && $urandom_range(99) < 50)
                add_payload(32'((area == 0 || $urandom_range(1)) ? area + 1 : area - 1));
            else
                add_payload($urandom_range(0, 20));
            // file cut short somewhere
            if ($urandom_range(99) < 8)
            begin
                keep = $urandom_range(1, file_q.size());
                while (file_q.size() > keep)
                    void'(file_q.pop_back());
            end
        end
        send_file();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // header spellings that strtol takes
    task automatic test_accepted_headers();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_text_file("1 1\n", 4);
        // every whitespace kind but newline, and a plus sign
        send_text_file(" \011+2\013\014\0153\n", 24);
        send_text_file("1\n2\n", 8);
        // height sign right after the width digits
        send_text_file("3+4\n", 48);
        send_text_file("0007 00002\n", 56);
        wait_drained();
    endtask

    task automatic test_rejected_headers();
        sender_idle_pct = 37;
        recv_stall_pct  = 37;
        // negative or zero values
        send_text_file("-1 1\n", 4);
        send_text_file("1 -1\n", 4);
        send_text_file("0 1\n", 0);
        send_text_file("1 0\n", 0);
        // oversize numbers saturate; largest dimensions with a short payload
        send_text_file("16385 1\n", 0);
        send_text_file("99999999999 1\n", 4);
        send_text_file("16384 16384\n", 4);
        // payload length off by one
        send_text_file("1 1\n", 3);
        send_text_file("1 1\n", 5);
        // height not ended by a newline
        send_text_file("1 1 \n", 4);
        // sign with no digit, junk before the number
        send_text_file("+ 1 1\n", 4);
        send_text_file("x1 1\n", 4);
        // bad signature byte, then a good header that must be ignored
        file_q.delete();
        add_signature(MAGIC_LEN);
        file_q[3] = 8'hFF;
        add_text("1 1\n");
        add_payload(4);
        send_file();
        wait_drained();
    endtask

    task automatic test_truncated_files();
        sender_idle_pct = 80;
        recv_stall_pct  = 0;
        // final byte is the last digit of the height
        send_text_file("2 2", 0);
        // final byte is the newline, no payload
        send_text_file("2 2\n", 0);
        // final byte inside the signature
        file_q.delete();
        add_signature(6);
        send_file();
        // single byte file, then a good file to show the parser restarted
        file_q.delete();
        file_q.push_back(8'h00);
        send_file();
        send_text_file("1 2\n", 8);
        wait_drained();
    endtask

    // largest legal width and height in the header, payloads kept short
    task automatic test_max_dimensions();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_text_file("16384 1\n", 4);
        send_text_file("1 16384\n", 8);
        wait_drained();
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned live_start;
        int unsigned files_start;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        live_start  = live_bytes;
        files_start = files_sent;
        while (live_bytes - live_start < 40 || files_sent - files_start < 2)
        begin
            send_random_file();
            // now and then let the result side empty out completely
            if ($urandom_range(99) < 5)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_random_files();
        run_random_phase(0, 0);
        run_random_phase(80, 0);
        run_random_phase(0, 80);
        run_random_phase(37, 37);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        byte_chan.valid     = 1'b0;
        byte_chan.data_byte = 8'h00;
        byte_chan.last_byte = 1'b0;
        sender_idle_pct     = 0;
        recv_stall_pct      = 0;
        err_count           = 0;
        live_bytes          = 0;
        files_sent          = 0;
        clear_parser();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_accepted_headers();
        test_rejected_headers();
        test_truncated_files();
        test_max_dimensions();
        test_random_files();

        // wait for every verdict, then let the pipeline idle before the summary
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
